### design/sofx_pkg.sv
// shared constants, payload types and control structs for the start-of-frame deframer
`timescale 1ns / 1ps
`default_nettype none

package sofx_pkg;

    // default frame geometry
    localparam int HEADER_BYTES_DEF  = 7;
    localparam int TRAILER_BYTES_DEF = 2;
    localparam int MAX_PAYLOAD_DEF   = 256;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 9;
    localparam int MAXLEN_W = 9;
    localparam int LEN_W    = 16;

    // start pattern and header layout
    localparam logic [BYTE_W-1:0] SOF_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SOF_SECOND = 8'h55;
    localparam int SOF_BYTES   = 2;
    localparam int LEN_POS_A   = 5;
    localparam int LEN_POS_B   = 6;

    // queue between classifier and result generator
    localparam int QUEUE_DEPTH = 4;

    // register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_LEN    = 1'b0;
    localparam logic REG_LEN_ENDIAN = 1'b1;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 9'd256;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              frame_end;
        logic              frame_dropped;
        logic              run_last;
    } out_item_t;

    typedef struct packed {
        logic [MAXLEN_W-1:0] max_len;
        logic                big_endian;
    } cfg_t;

    // one classified byte; is_sof stands for the two start bytes
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              frame_end;
        logic              frame_dropped;
        logic              is_sof;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

### design/sofx_stream_if.sv
// valid/ready stream interface with a typed payload
`timescale 1ns / 1ps
`default_nettype none

interface sofx_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/sofx_front.sv
// byte classifier: start hunt, header parse, length check and frame count
`timescale 1ns / 1ps
`default_nettype none

module sofx_front #(
    parameter int HEADER_BYTES  = sofx_pkg::HEADER_BYTES_DEF,
    parameter int TRAILER_BYTES = sofx_pkg::TRAILER_BYTES_DEF,
    parameter int MAX_PAYLOAD   = sofx_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    sofx_stream_if.sink             rx,
    input  sofx_pkg::cfg_t          cfg,
    input  sofx_pkg::queue_status_t q_status,
    output logic                    push,
    output sofx_pkg::entry_t        push_entry
);

    localparam int TOTAL_MAX = HEADER_BYTES + MAX_PAYLOAD + TRAILER_BYTES;
    localparam int CW_RAW    = $clog2(TOTAL_MAX + 1);
    localparam int COUNT_W   = (CW_RAW > sofx_pkg::POS_W) ? CW_RAW : sofx_pkg::POS_W;
    localparam int LEN_W     = sofx_pkg::LEN_W;

    localparam logic [COUNT_W-1:0] HDR_LAST  = COUNT_W'(HEADER_BYTES - 1);
    localparam logic [COUNT_W-1:0] FIXED_LEN = COUNT_W'(HEADER_BYTES + TRAILER_BYTES);
    localparam logic [COUNT_W-1:0] SOF_COUNT = COUNT_W'(sofx_pkg::SOF_BYTES);
    localparam logic [COUNT_W-1:0] POS_A     = COUNT_W'(sofx_pkg::LEN_POS_A);
    localparam logic [COUNT_W-1:0] POS_B     = COUNT_W'(sofx_pkg::LEN_POS_B);
    localparam logic [LEN_W-1:0]   MAX_PAY   = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        ST_HUNT1  = 4'b0001,
        ST_HUNT2  = 4'b0010,
        ST_HEADER = 4'b0100,
        ST_BODY   = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [COUNT_W-1:0]              count_reg, count_next;
    logic [COUNT_W-1:0]              total_reg, total_next;
    logic [LEN_W-1:0]                payload_len_reg, payload_len_next;
    logic [sofx_pkg::BYTE_W-1:0]     len_first_reg, len_first_next;

    logic                            accept;
    logic [sofx_pkg::BYTE_W-1:0]     b;
    logic [LEN_W-1:0]                assembled;
    logic [LEN_W-1:0]                len_now;
    logic [LEN_W-1:0]                limit;
    logic                            over;
    logic [COUNT_W-1:0]              total_now;
    logic [COUNT_W-1:0]              count_inc;

    assign rx.ready = !q_status.full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.payload.rx_byte;

    always_comb
    begin
        assembled = cfg.big_endian ? {len_first_reg, b} : {b, len_first_reg};
        len_now   = (count_reg == POS_B) ? assembled : payload_len_reg;
        // register limit saturates at the build-time maximum
        limit     = (LEN_W'(cfg.max_len) > MAX_PAY) ? MAX_PAY : LEN_W'(cfg.max_len);
        over      = len_now > limit;
        // only used when the length is within the limit, so it fits
        total_now = FIXED_LEN + COUNT_W'(len_now);
        count_inc = count_reg + COUNT_W'(1);
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        payload_len_next = payload_len_reg;
        len_first_next   = len_first_reg;
        push             = 1'b0;
        push_entry       = '{data_byte:     b,
                             position:      count_reg[sofx_pkg::POS_W-1:0],
                             frame_end:     1'b0,
                             frame_dropped: 1'b0,
                             is_sof:        1'b0};
        if (accept)
        begin
            case (state_reg)
                ST_HUNT1:
                begin
                    if (b == sofx_pkg::SOF_FIRST)
                        state_next = ST_HUNT2;
                end
                ST_HUNT2:
                begin
                    if (b == sofx_pkg::SOF_SECOND)
                    begin
                        state_next        = ST_HEADER;
                        count_next        = SOF_COUNT;
                        push              = 1'b1;
                        push_entry.is_sof = 1'b1;
                    end
                    else if (b != sofx_pkg::SOF_FIRST)
                    begin
                        state_next = ST_HUNT1;
                    end
                end
                ST_HEADER:
                begin
                    push       = 1'b1;
                    count_next = count_inc;
                    if (count_reg == POS_A)
                        len_first_next = b;
                    if (count_reg == POS_B)
                        payload_len_next = assembled;
                    if (count_reg == HDR_LAST)
                    begin
                        if (over)
                        begin
                            push_entry.frame_dropped = 1'b1;
                            state_next               = ST_HUNT1;
                        end
                        else if (count_inc >= total_now)
                        begin
                            push_entry.frame_end = 1'b1;
                            state_next           = ST_HUNT1;
                        end
                        else
                        begin
                            state_next = ST_BODY;
                            total_next = total_now;
                        end
                    end
                end
                ST_BODY:
                begin
                    push       = 1'b1;
                    count_next = count_inc;
                    if (count_inc >= total_reg)
                    begin
                        push_entry.frame_end = 1'b1;
                        state_next           = ST_HUNT1;
                    end
                end
                default:
                begin
                    state_next = ST_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_HUNT1;
            count_reg       <= '0;
            total_reg       <= '0;
            payload_len_reg <= '0;
            len_first_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            payload_len_reg <= payload_len_next;
            len_first_reg   <= len_first_next;
        end
    end

    // start pattern always opens the header at position two
    a_sof_opens_header: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (state_reg == ST_HUNT2) && (b == sofx_pkg::SOF_SECOND)
        |=> (state_reg == ST_HEADER) && (count_reg == SOF_COUNT))
        else $error("start pattern did not open a header");

    // never push into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push while queue full");

    a_header_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEADER) |-> (count_reg >= SOF_COUNT) && (count_reg <= HDR_LAST))
        else $error("header count out of range");

    a_body_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY) |-> (count_reg < total_reg))
        else $error("body count past frame end");

endmodule

`default_nettype wire

### design/sofx_queue.sv
// short register queue between classifier and result generator
`timescale 1ns / 1ps
`default_nettype none

module sofx_queue #(
    parameter int DEPTH = sofx_pkg::QUEUE_DEPTH
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  logic                    push,
    input  sofx_pkg::entry_t        push_entry,
    input  logic                    pop,
    output sofx_pkg::entry_t        head,
    output sofx_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sofx_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

endmodule

`default_nettype wire

### design/sofx_back.sv
// result generator: expands queue entries into output transactions
`timescale 1ns / 1ps
`default_nettype none

module sofx_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  sofx_pkg::entry_t        head,
    input  sofx_pkg::queue_status_t q_status,
    output logic                    pop,
    sofx_stream_if.source           frames
);

    logic                 out_valid_reg, out_valid_next;
    sofx_pkg::out_item_t  out_item_reg, out_item_next;
    logic                 second_reg, second_next;
    logic                 load;

    assign load           = !out_valid_reg || frames.ready;
    assign frames.valid   = out_valid_reg;
    assign frames.payload = out_item_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                if (head.is_sof)
                begin
                    // start pattern: two transactions, entry retired on the second
                    out_item_next.frame_end     = 1'b0;
                    out_item_next.frame_dropped = 1'b0;
                    if (!second_reg)
                    begin
                        out_item_next.data_byte = sofx_pkg::SOF_FIRST;
                        out_item_next.position  = '0;
                        out_item_next.run_last  = 1'b0;
                        second_next             = 1'b1;
                    end
                    else
                    begin
                        out_item_next.data_byte = sofx_pkg::SOF_SECOND;
                        out_item_next.position  = sofx_pkg::POS_W'(1);
                        out_item_next.run_last  = 1'b1;
                        second_next             = 1'b0;
                        pop                     = 1'b1;
                    end
                end
                else
                begin
                    out_item_next.data_byte     = head.data_byte;
                    out_item_next.position      = head.position;
                    out_item_next.frame_end     = head.frame_end;
                    out_item_next.frame_dropped = head.frame_dropped;
                    out_item_next.run_last      = 1'b1;
                    pop                         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // the start entry stays at the head until its second transaction is loaded
    a_second_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !q_status.empty && head.is_sof)
        else $error("second start transaction without its entry");

endmodule

`default_nettype wire

### design/sof_length_frame_extractor_top.sv
// top level of the start-of-frame length-prefixed deframer with its register port
//
//   channel  role    transaction payload
//   -------  ------  -----------------------------------------------------------
//   rx       sink    rx_byte
//   frames   source  data_byte, position, frame_end, frame_dropped, run_last
//   apb      slave   max_payload_len at 0x0, length_big_endian at 0x4
//
// one byte is taken per cycle while the classifier queue has room; a taken
// byte is written into the queue, then loaded into the output register.
// the start pattern produces two output transactions from one queue entry,
// so that byte holds the result generator for both; the queue absorbs it.
// reset clears parse state, queue pointers and the output valid; registers
// return to max_payload_len 256 and little-endian length.
// a stall on frames fills the queue; rx.ready drops only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module sof_length_frame_extractor_top #(
    parameter int HEADER_BYTES  = sofx_pkg::HEADER_BYTES_DEF,
    parameter int TRAILER_BYTES = sofx_pkg::TRAILER_BYTES_DEF,
    parameter int MAX_PAYLOAD   = sofx_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    sofx_stream_if.sink                      rx,
    sofx_stream_if.source                    frames,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [sofx_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [sofx_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sofx_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    // configuration registers
    logic [sofx_pkg::MAXLEN_W-1:0] max_len_reg, max_len_next;
    logic                          big_endian_reg, big_endian_next;
    logic                          reg_index;
    logic                          cfg_write;
    sofx_pkg::cfg_t                cfg;

    // front to back
    logic                          push;
    logic                          pop;
    sofx_pkg::entry_t              push_entry;
    sofx_pkg::entry_t              head;
    sofx_pkg::queue_status_t       q_status;

    assign pready    = 1'b1;
    // word address selects the register; byte offset within the word is ignored
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        max_len_next    = max_len_reg;
        big_endian_next = big_endian_reg;
        if (cfg_write)
        begin
            case (reg_index)
                sofx_pkg::REG_MAX_LEN:    max_len_next    = pwdata[sofx_pkg::MAXLEN_W-1:0];
                sofx_pkg::REG_LEN_ENDIAN: big_endian_next = pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            sofx_pkg::REG_MAX_LEN:
                prdata = sofx_pkg::APB_DATA_W'(max_len_reg);
            sofx_pkg::REG_LEN_ENDIAN:
                prdata = sofx_pkg::APB_DATA_W'(big_endian_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= sofx_pkg::MAX_LEN_RESET;
            big_endian_reg <= 1'b0;
        end
        else
        begin
            max_len_reg    <= max_len_next;
            big_endian_reg <= big_endian_next;
        end
    end

    assign cfg.max_len    = max_len_reg;
    assign cfg.big_endian = big_endian_reg;

    // classifier: hunts the start pattern and tags every frame byte
    sofx_front #(
        .HEADER_BYTES  (HEADER_BYTES),
        .TRAILER_BYTES (TRAILER_BYTES),
        .MAX_PAYLOAD   (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples the input from output stalls
    sofx_queue #(
        .DEPTH (sofx_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // result generator with output register
    sofx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .frames   (frames)
    );

endmodule

`default_nettype wire

### verif/sof_length_frame_extractor_top_tb.sv
// self-checking testbench for the start-of-frame length-prefixed deframer top level
`timescale 1ns / 1ps

module sof_length_frame_extractor_top_tb;

    import sofx_pkg::*;

    // frame geometry of the instance under test (defaults of the top level)
    localparam int FRAME_HEADER  = HEADER_BYTES_DEF;
    localparam int FRAME_TRAILER = TRAILER_BYTES_DEF;
    localparam int PAYLOAD_CAP   = MAX_PAYLOAD_DEF;

    // register byte addresses: index times four
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LEN    = {REG_MAX_LEN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LEN_ENDIAN = {REG_LEN_ENDIAN, 2'b00};

    // bytes may still sit in the four-deep queue and the output register; this covers them with margin
    localparam int SETTLE_CYCLES   = 32;
    // long receiver hold-off so the classifier queue fills and rx.ready drops
    localparam int HOLD_OFF_CYCLES = 150;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT     = 4000;
    localparam int REPORT_MAX      = 10;
    localparam int PHASE_BYTES     = 255;

    // parse phases of the deframer
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        IN_HEADER,
        IN_BODY
    } parse_phase_e;

    logic clk = 1'b0;
    logic rst_n;

    sofx_stream_if #(.payload_t(in_item_t))  rx_if ();
    sofx_stream_if #(.payload_t(out_item_t)) frames_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sof_length_frame_extractor_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .frames  (frames_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns clock, first rising edge at 4 ns
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // bytes waiting to be offered on rx, and frame bytes still owed on frames
    logic [BYTE_W-1:0] rx_backlog[$];
    out_item_t         frame_bytes_due[$];
    int unsigned       bytes_queued = 0;

    // idle percentages of both sides, and the long receiver hold-off
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    bit          hold_armed   = 1'b0;
    logic        hold_off     = 1'b0;

    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;

    // testbench copy of the registers, updated when a write is done
    logic [MAXLEN_W-1:0] cfg_max_len    = MAX_LEN_RESET;
    logic                cfg_big_endian = 1'b0;

    // deframer state as the testbench tracks it
    parse_phase_e      phase_m     = HUNT_FIRST;
    int unsigned       frame_idx   = 0;
    logic [LEN_W-1:0]  len_m       = '0;
    logic [BYTE_W-1:0] len_first_m = '0;

    // register limit saturated to the payload capacity of the instance
    function automatic int unsigned payload_limit();
        return (cfg_max_len > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(cfg_max_len);
    endfunction

    function automatic string fmt_frame_byte(input out_item_t r);
        return $sformatf("data %02h pos %0d end %0b drop %0b last %0b",
                         r.data_byte, r.position, r.frame_end, r.frame_dropped, r.run_last);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("[%0t] ERROR %s", $realtime, msg);
    endtask

    task automatic owe_frame_byte(input logic [BYTE_W-1:0] d, input int unsigned pos,
                                  input logic fend, input logic fdrop, input logic last);
        out_item_t r;
        r.data_byte     = d;
        r.position      = POS_W'(pos);
        r.frame_end     = fend;
        r.frame_dropped = fdrop;
        r.run_last      = last;
        frame_bytes_due.push_back(r);
    endtask

    // advance the tracked deframer by one accepted byte and record what it owes
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        int unsigned pos;
        int unsigned frame_len;
        case (phase_m)
            HUNT_FIRST:
            begin
                if (b == SOF_FIRST)
                    phase_m = HUNT_SECOND;
            end
            HUNT_SECOND:
            begin
                if (b == SOF_SECOND)
                begin
                    // both start bytes come out as one run of two
                    phase_m   = IN_HEADER;
                    frame_idx = SOF_BYTES;
                    owe_frame_byte(SOF_FIRST, 0, 1'b0, 1'b0, 1'b0);
                    owe_frame_byte(SOF_SECOND, 1, 1'b0, 1'b0, 1'b1);
                end
                else if (b != SOF_FIRST)
                    phase_m = HUNT_FIRST;
            end
            IN_HEADER:
            begin
                pos = frame_idx;
                if (pos == LEN_POS_A)
                    len_first_m = b;
                else if (pos == LEN_POS_B)
                    len_m = cfg_big_endian ? {len_first_m, b} : {b, len_first_m};
                frame_idx = pos + 1;
                frame_len = FRAME_HEADER + len_m + FRAME_TRAILER;
                if (frame_idx < FRAME_HEADER)
                    owe_frame_byte(b, pos, 1'b0, 1'b0, 1'b1);
                else if (len_m > payload_limit())
                begin
                    // oversized length: flag the last header byte and hunt again
                    phase_m = HUNT_FIRST;
                    owe_frame_byte(b, pos, 1'b0, 1'b1, 1'b1);
                end
                else if (frame_idx >= frame_len)
                begin
                    phase_m = HUNT_FIRST;
                    owe_frame_byte(b, pos, 1'b1, 1'b0, 1'b1);
                end
                else
                begin
                    phase_m = IN_BODY;
                    owe_frame_byte(b, pos, 1'b0, 1'b0, 1'b1);
                end
            end
            default:
            begin
                pos       = frame_idx;
                frame_idx = pos + 1;
                frame_len = FRAME_HEADER + len_m + FRAME_TRAILER;
                if (frame_idx >= frame_len)
                begin
                    phase_m = HUNT_FIRST;
                    owe_frame_byte(b, pos, 1'b1, 1'b0, 1'b1);
                end
                else
                    owe_frame_byte(b, pos, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endtask

    // rx driver: a transaction is taken when valid and ready meet at a rising edge;
    // valid is only changed when the current byte is gone or none is offered
    always @(posedge clk or negedge rst_n)
    begin : rx_driver
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.payload <= '0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
                deframe_byte(rx_if.payload.rx_byte);
            if (!rx_if.valid || rx_if.ready)
            begin
                if (rx_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    rx_if.valid           <= 1'b1;
                    rx_if.payload.rx_byte <= rx_backlog.pop_front();
                end
                else
                    rx_if.valid <= 1'b0;
            end
        end
    end

    // frames monitor: check each transaction against the oldest owed frame byte
    always @(posedge clk or negedge rst_n)
    begin : frames_monitor
        out_item_t got;
        out_item_t want;
        if (!rst_n)
            frames_if.ready <= 1'b0;
        else
        begin
            if (frames_if.valid && frames_if.ready)
            begin
                got = frames_if.payload;
                if (frame_bytes_due.size() == 0)
                    note_error({"unexpected frame byte: ", fmt_frame_byte(got)});
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (got !== want)
                        note_error({"expected ", fmt_frame_byte(want),
                                    " / actual ", fmt_frame_byte(got)});
                end
            end
            frames_if.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // long hold-off on frames, counted here while the driver keeps offering bytes
    initial
    begin : receiver_hold_off
        wait (hold_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog: any rx or frames transaction restarts the count
    always @(posedge clk or negedge rst_n)
    begin : stall_watchdog
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((rx_if.valid && rx_if.ready) || (frames_if.valid && frames_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("[%0t] timeout: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    // one frame with optional extra leading 0xAA; an oversized length stops after the header
    task automatic queue_frame(input int unsigned payload_len, input int unsigned extra_aa);
        logic [LEN_W-1:0] len;
        len = LEN_W'(payload_len);
        repeat (extra_aa) queue_byte(SOF_FIRST);
        queue_byte(SOF_FIRST);
        queue_byte(SOF_SECOND);
        repeat (LEN_POS_A - SOF_BYTES) queue_byte(BYTE_W'($urandom_range(255)));
        if (cfg_big_endian)
        begin
            queue_byte(len[15:8]);
            queue_byte(len[7:0]);
        end
        else
        begin
            queue_byte(len[7:0]);
            queue_byte(len[15:8]);
        end
        if (payload_len <= payload_limit())
            repeat (payload_len + FRAME_TRAILER) queue_byte(BYTE_W'($urandom_range(255)));
    endtask

    // mostly well-formed frames with random content, some oversized lengths,
    // some line noise and some broken start patterns
    task automatic queue_random_traffic(input int unsigned budget);
        int unsigned start_count;
        int unsigned lim;
        int unsigned pick;
        int unsigned len;
        logic [BYTE_W-1:0] b;
        start_count = bytes_queued;
        while (bytes_queued - start_count < budget)
        begin
            lim  = payload_limit();
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // short payloads most of the time, the full range and the limit now and then
                pick = $urandom_range(99);
                if (pick < 85)
                    len = $urandom_range((lim < 24) ? lim : 24, 0);
                else if (pick < 95)
                    len = $urandom_range(lim, 0);
                else
                    len = lim;
                queue_frame(len, ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0);
            end
            else if (pick < 82)
            begin
                len = $urandom_range(1) ? lim + 1 : $urandom_range(65535, lim + 1);
                queue_frame(len, 0);
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    b = BYTE_W'($urandom_range(255));
                    queue_byte((b == SOF_FIRST) ? ~b : b);
                end
            end
            else
            begin
                // run of 0xAA broken by a byte that is no start byte
                repeat ($urandom_range(3, 1)) queue_byte(SOF_FIRST);
                b = BYTE_W'($urandom_range(255));
                queue_byte((b == SOF_FIRST || b == SOF_SECOND) ? 8'h00 : b);
            end
        end
    endtask

    // register write: setup, then access until pready
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // both registers, upper bits of the words are don't-care for the block
    task automatic write_config(input logic [APB_DATA_W-1:0] max_word,
                                input logic [APB_DATA_W-1:0] endian_word);
        apb_write(ADDR_MAX_LEN, max_word);
        apb_write(ADDR_LEN_ENDIAN, endian_word);
        cfg_max_len    = max_word[MAXLEN_W-1:0];
        cfg_big_endian = endian_word[0];
    endtask

    // wait for every byte to be taken and every owed frame byte to arrive,
    // then let hunting bytes still inside the block run out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (rx_backlog.size() != 0 || rx_if.valid || frame_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : main_sequence
        logic [APB_DATA_W-1:0] noisy_max;

        // known values on every input from time zero
        rst_n           = 1'b0;
        rx_if.valid     = 1'b0;
        rx_if.payload   = '0;
        frames_if.ready = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles a little, receiver a lot
        src_idle_pct = 17;
        snk_idle_pct = 62;

        // directed part, reset register values (limit 256, little-endian)
        // hunting noise, lone 0x55, extremes of the byte
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(SOF_SECOND);
        // repeated 0xAA keeps waiting for 0x55, then an empty frame
        queue_byte(SOF_FIRST);
        queue_byte(SOF_FIRST);
        queue_byte(SOF_FIRST);
        queue_byte(SOF_SECOND);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        // 0xAA followed by something else falls back to hunting
        queue_byte(SOF_FIRST);
        queue_byte(8'h13);
        // length 257, one above the limit: dropped on the last header byte
        queue_byte(SOF_FIRST);
        queue_byte(SOF_SECOND);
        queue_byte(8'h01);
        queue_byte(8'h02);
        queue_byte(8'h03);
        queue_byte(8'h01);
        queue_byte(8'h01);
        wait_drained();

        // all-ones words: limit 511 saturates to the capacity, little-endian
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // limit zero, big-endian: only empty payloads pass
        write_config(32'h0000_0000, 32'h0000_0001);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // now the sender idles a lot and the receiver a little
        src_idle_pct = 62;
        snk_idle_pct = 17;

        // random limit with garbage above bit 8, big-endian
        noisy_max = ($urandom() & ~32'h1FF) | $urandom_range(300, 1);
        write_config(noisy_max, 32'h0000_0003);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        write_config(32'h0000_0100, 32'h0000_0000);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;

        // long receiver stall while the sender keeps going, queue must fill
        write_config(32'h0000_00FF, 32'hFFFF_FFFF);
        queue_random_traffic(PHASE_BYTES);
        hold_armed = 1'b1;
        wait_drained();

        write_config(32'h0000_0028, 32'h0000_0000);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // owed frame bytes left at the end are failures too
        error_count += frame_bytes_due.size();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
